// ----- rtl/fnvht_pkg.sv -----
// Shared constants, types and state encodings for the FNV-1a hash table.
`default_nettype none

package fnvht_pkg;

    // Table geometry; SLOTS must be a power of two, as the hash is masked to it.
    localparam int SLOTS       = 1024;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 3;
    localparam int KEY_CNT_W   = $clog2(KEY_BYTES + 1);

    // 64-bit FNV-1a constants. The prime is 2^40 + 0x1B3, so the multiply
    // becomes a shift plus a narrow product.
    localparam logic [KEY_W-1:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]       FNV_MULT_LO    = 9'h1B3;
    localparam int               FNV_MULT_SHIFT = 40;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND    = 3'd0,
        STATUS_MISSING  = 3'd1,
        STATUS_INSERTED = 3'd2,
        STATUS_UPDATED  = 3'd3,
        STATUS_FULL     = 3'd4
    } status_t;

    // Request opcodes.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } opcode_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_CHECK,
        FSM_RESP
    } fsm_state_t;

    // One slot as held in the table memory.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Status from the hash unit to the sequencer.
    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] hash;
    } hash_res_t;

endpackage

`default_nettype wire

// ----- rtl/fnvht_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fnvht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/fnvht_hash.sv -----
// Iterative 64-bit FNV-1a hash unit, one key byte per cycle.
`default_nettype none

module fnvht_hash (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [fnvht_pkg::KEY_W-1:0] key_in,
    output fnvht_pkg::hash_res_t            res
);

    logic                           busy_reg;
    logic [fnvht_pkg::KEY_W-1:0]    h_reg;
    logic [fnvht_pkg::KEY_W-1:0]    key_reg;
    logic [fnvht_pkg::KEY_CNT_W-1:0] cnt_reg;

    logic [7:0]                     cur_byte;
    logic                           last;
    logic [fnvht_pkg::KEY_W-1:0]    mixed;
    logic [fnvht_pkg::KEY_W-1:0]    h_next;

    // The key ends at its first zero byte or after the last byte.
    assign cur_byte = key_reg[7:0];
    assign last     = (cur_byte == 8'd0) ||
                      (cnt_reg == fnvht_pkg::KEY_CNT_W'(fnvht_pkg::KEY_BYTES));

    // One FNV-1a round: xor in the byte, then multiply by the prime as
    // a shift by 40 plus a product with the 9-bit low part.
    assign mixed  = h_reg ^ {{(fnvht_pkg::KEY_W-8){1'b0}}, cur_byte};
    assign h_next = (mixed << fnvht_pkg::FNV_MULT_SHIFT) +
                    (mixed * {{(fnvht_pkg::KEY_W-9){1'b0}}, fnvht_pkg::FNV_MULT_LO});

    // Busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && last) begin
            busy_reg <= 1'b0;
        end
    end

    // Hash state and remaining key bytes.
    always_ff @(posedge aclk) begin
        if (start) begin
            h_reg   <= fnvht_pkg::FNV_BASIS;
            key_reg <= key_in;
            cnt_reg <= '0;
        end else if (busy_reg && !last) begin
            h_reg   <= h_next;
            key_reg <= key_reg >> 8;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign res.done = busy_reg && last;
    assign res.hash = h_reg;

endmodule

`default_nettype wire

// ----- rtl/fnv1a_linear_probe_hash_table.sv -----
// Top level of the FNV-1a key-value store with linear probing.
//
// The s_ channel carries requests (get or set of a key of up to eight bytes,
// ending at the first zero byte); the m_ channel returns one result per
// request: status, the stored value on a hit, and the number of occupied
// slots. Both channels use valid/ready handshakes.
// A request is hashed one key byte per cycle, then the table memory is probed
// one slot per cycle through its registered read port. The next request is
// taken only once the result has moved into the output register.
// After reset the block sweeps the table memory, one slot a cycle, clearing
// every valid flag, and s_ready stays low until the sweep ends. The entry
// count is cleared at once.
// A result sits in an output register until taken; the next request may be
// accepted meanwhile, but a finished result waits for that register to free
// up when the receiver stalls.
`default_nettype none

module fnv1a_linear_probe_hash_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_opcode,
    input  wire logic [fnvht_pkg::KEY_W-1:0]     s_key,
    input  wire logic [fnvht_pkg::VALUE_W-1:0]   s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [fnvht_pkg::STATUS_W-1:0]       m_status,
    output logic [fnvht_pkg::VALUE_W-1:0]        m_value_out,
    output logic [fnvht_pkg::COUNT_W-1:0]        m_entries
);

    fnvht_pkg::fsm_state_t              state_reg, state_next;
    logic [fnvht_pkg::IDX_W-1:0]        clr_addr_reg;
    logic [fnvht_pkg::COUNT_W-1:0]      count_reg;
    logic                               m_valid_reg, m_valid_next;

    // Request held for the whole transaction.
    fnvht_pkg::opcode_t                 op_reg;
    logic [fnvht_pkg::KEY_W-1:0]        nkey_reg;
    logic [fnvht_pkg::VALUE_W-1:0]      value_reg;
    logic [fnvht_pkg::IDX_W-1:0]        idx_reg;
    logic [fnvht_pkg::IDX_W-1:0]        probe_reg;
    fnvht_pkg::status_t                 status_reg;
    logic [fnvht_pkg::VALUE_W-1:0]      vout_reg;

    logic [fnvht_pkg::STATUS_W-1:0]     m_status_reg;
    logic [fnvht_pkg::VALUE_W-1:0]      m_value_out_reg;
    logic [fnvht_pkg::COUNT_W-1:0]      m_entries_reg;

    logic [fnvht_pkg::KEY_W-1:0]        nkey;
    logic                               accept;
    logic                               out_free;
    fnvht_pkg::hash_res_t               hash_res;

    logic                               ram_wr_en;
    logic [fnvht_pkg::IDX_W-1:0]        ram_wr_addr;
    fnvht_pkg::slot_t                   ram_wr_data;
    logic [fnvht_pkg::IDX_W-1:0]        ram_rd_addr;
    logic [fnvht_pkg::SLOT_W-1:0]       ram_rd_data;
    fnvht_pkg::slot_t                   rd_slot;

    logic                               slot_empty;
    logic                               slot_hit;
    logic                               last_probe;
    logic                               check_done;
    logic                               count_inc;
    fnvht_pkg::status_t                 status_next;
    logic [fnvht_pkg::VALUE_W-1:0]      vout_next;

    // Clear the key bytes after the first zero byte.
    always_comb begin
        logic alive;
        alive = 1'b1;
        nkey  = '0;
        for (int i = 0; i < fnvht_pkg::KEY_BYTES; i++) begin
            alive = alive && (s_key[8*i +: 8] != 8'd0);
            nkey[8*i +: 8] = alive ? s_key[8*i +: 8] : 8'd0;
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    fnvht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key_in  (nkey),
        .res     (hash_res)
    );

    fnvht_ram #(
        .WIDTH (fnvht_pkg::SLOT_W),
        .DEPTH (fnvht_pkg::SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Compare the slot read on the previous cycle with the request.
    assign rd_slot    = fnvht_pkg::slot_t'(ram_rd_data);
    assign slot_empty = !rd_slot.valid;
    assign slot_hit   = rd_slot.valid && (rd_slot.key == nkey_reg);
    assign last_probe = (probe_reg == fnvht_pkg::IDX_W'(fnvht_pkg::SLOTS - 1));
    assign check_done = slot_empty || slot_hit || last_probe;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fnvht_pkg::FSM_CLEAR: begin
                if (clr_addr_reg == fnvht_pkg::IDX_W'(fnvht_pkg::SLOTS - 1)) begin
                    state_next = fnvht_pkg::FSM_IDLE;
                end
            end
            fnvht_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    state_next = fnvht_pkg::FSM_HASH;
                end
            end
            fnvht_pkg::FSM_HASH: begin
                if (hash_res.done) begin
                    state_next = fnvht_pkg::FSM_CHECK;
                end
            end
            fnvht_pkg::FSM_CHECK: begin
                if (check_done) begin
                    state_next = fnvht_pkg::FSM_RESP;
                end
            end
            fnvht_pkg::FSM_RESP: begin
                if (out_free) begin
                    state_next = fnvht_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = fnvht_pkg::FSM_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory accesses and the probe outcome.
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = '{valid: 1'b1, key: nkey_reg, value: value_reg};
        ram_rd_addr = idx_reg + 1'b1;
        count_inc   = 1'b0;
        status_next = fnvht_pkg::STATUS_MISSING;
        vout_next   = '0;
        unique case (state_reg)
            fnvht_pkg::FSM_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            fnvht_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
            end
            fnvht_pkg::FSM_HASH: begin
                ram_rd_addr = hash_res.hash[fnvht_pkg::IDX_W-1:0];
            end
            fnvht_pkg::FSM_CHECK: begin
                if (slot_empty) begin
                    if (op_reg == fnvht_pkg::OP_SET) begin
                        ram_wr_en   = 1'b1;
                        count_inc   = 1'b1;
                        status_next = fnvht_pkg::STATUS_INSERTED;
                    end else begin
                        status_next = fnvht_pkg::STATUS_MISSING;
                    end
                end else if (slot_hit) begin
                    if (op_reg == fnvht_pkg::OP_SET) begin
                        ram_wr_en   = 1'b1;
                        status_next = fnvht_pkg::STATUS_UPDATED;
                    end else begin
                        vout_next   = rd_slot.value;
                        status_next = fnvht_pkg::STATUS_FOUND;
                    end
                end else if (op_reg == fnvht_pkg::OP_SET) begin
                    status_next = fnvht_pkg::STATUS_FULL;
                end else begin
                    status_next = fnvht_pkg::STATUS_MISSING;
                end
            end
            fnvht_pkg::FSM_RESP: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (state_reg == fnvht_pkg::FSM_RESP && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fnvht_pkg::FSM_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == fnvht_pkg::FSM_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (count_inc) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Request capture, probe position and result registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= fnvht_pkg::opcode_t'(s_opcode);
            nkey_reg  <= nkey;
            value_reg <= s_value;
        end
        if (state_reg == fnvht_pkg::FSM_HASH && hash_res.done) begin
            idx_reg   <= hash_res.hash[fnvht_pkg::IDX_W-1:0];
            probe_reg <= '0;
        end else if (state_reg == fnvht_pkg::FSM_CHECK && !check_done) begin
            idx_reg   <= idx_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
        end
        if (state_reg == fnvht_pkg::FSM_CHECK && check_done) begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
        end
        if (state_reg == fnvht_pkg::FSM_RESP && out_free) begin
            m_status_reg    <= status_reg;
            m_value_out_reg <= vout_reg;
            m_entries_reg   <= count_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_out_reg;
    assign m_entries   = m_entries_reg;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the FNV-1a linear-probing key-value store.
`timescale 1ns / 1ps

module testbench;
    import fnvht_pkg::*;

    // Hash constants of 64-bit FNV-1a, kept apart from the design's own encoding.
    localparam logic [KEY_W-1:0] HASH_SEED  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [KEY_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01B3;

    localparam int POOL_KEYS        = 40;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int FULL_TABLE_ITEMS = 40;
    localparam int TAIL_CYCLES      = 40;
    localparam int MAX_REPORTS      = 60;

    // One result as the m_ channel carries it.
    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0] entries;
    } reply_t;

    // One row of the directed stimulus; the reply is used only where fixed is set.
    typedef struct {
        opcode_t            op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 fixed;
        reply_t             reply;
    } stim_row_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_opcode = 1'b0;
    logic [KEY_W-1:0]    s_key    = '0;
    logic [VALUE_W-1:0]  s_value  = '0;
    logic                m_ready  = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_value_out;
    logic [COUNT_W-1:0]  m_entries;

    // Shadow copy of the table contents.
    logic               slot_used [SLOTS];
    logic [KEY_W-1:0]   slot_keys [SLOTS];
    logic [VALUE_W-1:0] slot_vals [SLOTS];
    int unsigned        stored_count;

    reply_t             replies_due [$];
    stim_row_t          directed_rows [$];
    logic [KEY_W-1:0]   key_pool [$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 error_count    = 0;

    fnv1a_linear_probe_hash_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out),
        .m_entries   (m_entries)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the design hangs.
    initial begin
        #80_000_000;
        $display("** fnv1a_linear_probe_hash_table: FAILED **");
        $finish;
    end

    // Clears every byte from the first zero byte upward.
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] kept;
        bit               ended;
        int               i;
        kept  = '0;
        ended = 1'b0;
        for (i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                kept[8*i +: 8] = raw[8*i +: 8];
        end
        return kept;
    endfunction

    // FNV-1a over the bytes of an already trimmed key.
    function automatic logic [KEY_W-1:0] fnv1a_of(input logic [KEY_W-1:0] norm);
        logic [KEY_W-1:0] h;
        int               i;
        h = HASH_SEED;
        for (i = 0; i < KEY_BYTES; i++) begin
            if (norm[8*i +: 8] != 8'h00)
                h = (h ^ {56'd0, norm[8*i +: 8]}) * HASH_PRIME;
        end
        return h;
    endfunction

    // Applies one request to the shadow table and returns the result it gives.
    function automatic reply_t table_access(input opcode_t op, input logic [KEY_W-1:0] raw,
                                            input logic [VALUE_W-1:0] val);
        logic [KEY_W-1:0] norm;
        logic [KEY_W-1:0] h;
        logic [IDX_W-1:0] idx;
        reply_t           r;
        bit               settled;
        int               n;
        norm        = trim_key(raw);
        h           = fnv1a_of(norm);
        idx         = h[IDX_W-1:0];
        r.status    = (op == OP_SET) ? STATUS_FULL : STATUS_MISSING;
        r.value_out = '0;
        settled     = 1'b0;
        for (n = 0; n < SLOTS && !settled; n++) begin
            if (!slot_used[idx]) begin
                if (op == OP_SET) begin
                    slot_used[idx] = 1'b1;
                    slot_keys[idx] = norm;
                    slot_vals[idx] = val;
                    stored_count++;
                    r.status = STATUS_INSERTED;
                end
                settled = 1'b1;
            end else if (slot_keys[idx] == norm) begin
                if (op == OP_SET) begin
                    slot_vals[idx] = val;
                    r.status = STATUS_UPDATED;
                end else begin
                    r.value_out = slot_vals[idx];
                    r.status = STATUS_FOUND;
                end
                settled = 1'b1;
            end else begin
                // The index is exactly as wide as the table, so it wraps by itself.
                idx = idx + 1'b1;
            end
        end
        r.entries = stored_count[COUNT_W-1:0];
        return r;
    endfunction

    // A key of len bytes, with random bytes above its end marker.
    function automatic logic [KEY_W-1:0] random_key(input int len);
        logic [KEY_W-1:0] k;
        int               i;
        k = {$urandom, $urandom};
        for (i = 0; i < KEY_BYTES; i++) begin
            if (i < len)
                k[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i == len)
                k[8*i +: 8] = 8'h00;
        end
        return k;
    endfunction

    // The same key as norm, with fresh noise in the bytes after its end.
    function automatic logic [KEY_W-1:0] key_variant(input logic [KEY_W-1:0] norm);
        logic [KEY_W-1:0] k;
        bit               ended;
        int               i;
        k     = {$urandom, $urandom};
        ended = 1'b0;
        for (i = 0; i < KEY_BYTES; i++) begin
            if (!ended) begin
                k[8*i +: 8] = norm[8*i +: 8];
                ended = (norm[8*i +: 8] == 8'h00);
            end
        end
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch in %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
        error_count++;
    endtask

    task automatic add_row(input opcode_t op, input logic [KEY_W-1:0] k,
                           input logic [VALUE_W-1:0] v, input bit fixed, input status_t st,
                           input logic [VALUE_W-1:0] vout, input logic [COUNT_W-1:0] cnt);
        stim_row_t row;
        row.op              = op;
        row.key             = k;
        row.value           = v;
        row.fixed           = fixed;
        row.reply.status    = st;
        row.reply.value_out = vout;
        row.reply.entries   = cnt;
        directed_rows.push_back(row);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    // Offers one request, waits for its transaction and records the awaited result.
    task automatic send_request(input opcode_t op, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v, input bit fixed,
                                input reply_t fixed_reply);
        reply_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_key    <= k;
        s_value  <= v;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        predicted = table_access(op, k, v);
        replies_due.push_back(fixed ? fixed_reply : predicted);
    endtask

    // Holds the sender back until every awaited result has come.
    task automatic wait_all_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
    endtask

    // Mostly traffic on a small set of keys, so that hits, updates and chains occur.
    task automatic random_request();
        opcode_t          op;
        logic [KEY_W-1:0] k;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            op = OP_SET;
            k  = key_variant(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end else if (pick < 85) begin
            op = OP_GET;
            k  = key_variant(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end else begin
            op = opcode_t'($urandom_range(0, 1));
            k  = random_key($urandom_range(0, KEY_BYTES));
        end
        send_request(op, k, random_value(), 1'b0, '0);
    endtask

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Compares every result transaction with the oldest awaited result.
    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unawaited result status", 64'(m_status), '0);
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_value_out !== want.value_out)
                    report_mismatch("value_out", 64'(m_value_out), 64'(want.value_out));
                if (m_entries !== want.entries)
                    report_mismatch("entries", 64'(m_entries), 64'(want.entries));
            end
        end
    end

    // Main sequence: reset, directed rows, random phases, filling, full table.
    initial begin : stimulus
        stim_row_t        row;
        opcode_t          op;
        logic [KEY_W-1:0] k;
        int               i;
        int               n;
        int               pick;

        for (i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_keys[i] = '0;
            slot_vals[i] = '0;
        end
        stored_count = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty table, the empty key, noise after the end, extremes of key and value.
        add_row(OP_GET, 64'h0, 32'h0, 1, STATUS_MISSING, 32'h0, 11'd0);
        add_row(OP_SET, 64'h0, 32'hFFFF_FFFF, 1, STATUS_INSERTED, 32'h0, 11'd1);
        add_row(OP_GET, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 1, STATUS_FOUND, 32'hFFFF_FFFF, 11'd1);
        add_row(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, STATUS_INSERTED, 32'h0, 11'd2);
        add_row(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, STATUS_FOUND, 32'h0, 11'd2);
        add_row(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 1, STATUS_UPDATED, 32'h0, 11'd2);
        add_row(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, STATUS_FOUND, 32'hA5A5_5A5A, 11'd2);
        add_row(OP_SET, 64'h0000_0000_0000_0041, 32'h1, 1, STATUS_INSERTED, 32'h0, 11'd3);
        add_row(OP_GET, 64'h1234_5678_9ABC_0041, 32'h0, 1, STATUS_FOUND, 32'h1, 11'd3);
        add_row(OP_SET, 64'hFF00_0000_0000_0041, 32'h2, 1, STATUS_UPDATED, 32'h0, 11'd3);
        add_row(OP_GET, 64'h0000_0000_0000_0041, 32'h0, 1, STATUS_FOUND, 32'h2, 11'd3);
        add_row(OP_GET, 64'h0000_0000_0000_4241, 32'h0, 1, STATUS_MISSING, 32'h0, 11'd3);
        add_row(OP_SET, 64'h0102_0304_0506_0708, 32'h8000_0000, 1, STATUS_INSERTED,
                32'h0, 11'd4);
        add_row(OP_GET, 64'h0807_0605_0403_0201, 32'h0, 1, STATUS_MISSING, 32'h0, 11'd4);
        add_row(OP_GET, 64'h0102_0304_0506_0708, 32'h0, 1, STATUS_FOUND, 32'h8000_0000, 11'd4);
        add_row(OP_SET, 64'h8080_8080_8080_8080, 32'h1, 1, STATUS_INSERTED, 32'h0, 11'd5);
        add_row(OP_SET, 64'h7F7F_7F7F_7F7F_7F7F, 32'h7FFF_FFFF, 1, STATUS_INSERTED,
                32'h0, 11'd6);
        add_row(OP_GET, 64'h0000_0000_0000_0080, 32'h0, 1, STATUS_MISSING, 32'h0, 11'd6);
        add_row(OP_GET, 64'h7F7F_7F7F_7F7F_7F7F, 32'hFFFF_FFFF, 1, STATUS_FOUND,
                32'h7FFF_FFFF, 11'd6);
        add_row(OP_SET, 64'hAAAA_AAAA_AAAA_AA00, 32'h5555_5555, 1, STATUS_UPDATED, 32'h0, 11'd6);
        add_row(OP_GET, 64'h0, 32'h0, 1, STATUS_FOUND, 32'h5555_5555, 11'd6);
        // Rows below are checked against the shadow table.
        add_row(OP_SET, 64'h0011_2233_4455_6677, 32'h1357_9BDF, 0, STATUS_FOUND, 32'h0, 11'd0);
        add_row(OP_GET, 64'hEE11_2233_4455_6677, 32'h0, 0, STATUS_FOUND, 32'h0, 11'd0);
        add_row(OP_SET, 64'hC3C3_C3C3_C3C3_C3C3, 32'h3C3C_3C3C, 0, STATUS_FOUND, 32'h0, 11'd0);
        add_row(OP_GET, 64'hC3C3_C3C3_C3C3_C3C3, 32'h0, 0, STATUS_FOUND, 32'h0, 11'd0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.op, row.key, row.value, row.fixed, row.reply);
        end
        wait_all_replies();

        // Random traffic over a key pool, once per idling pattern.
        for (i = 0; i < POOL_KEYS; i++)
            key_pool.push_back(trim_key(random_key($urandom_range(1, KEY_BYTES))));
        for (i = 0; i < 4; i++) begin
            set_idling(i);
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                random_request();
            wait_all_replies();
        end

        // Fill every slot, so that long probe runs and wrap-around occur.
        n = 0;
        while (stored_count < SLOTS) begin
            set_idling((n / 128) % 4);
            send_request(OP_SET, random_key($urandom_range(1, KEY_BYTES)), random_value(),
                         1'b0, '0);
            n++;
        end
        wait_all_replies();

        // Full table: new keys are refused, misses take a whole pass, hits still work.
        for (n = 0; n < FULL_TABLE_ITEMS; n++) begin
            set_idling(n % 4);
            pick = $urandom_range(0, 3);
            if (pick < 2) begin
                op = opcode_t'(pick);
                k  = random_key($urandom_range(1, KEY_BYTES));
            end else begin
                op = opcode_t'($urandom_range(0, 1));
                k  = key_variant(slot_keys[$urandom_range(0, SLOTS - 1)]);
            end
            send_request(op, k, random_value(), 1'b0, '0);
        end

        wait_all_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && replies_due.size() == 0)
            $display("** fnv1a_linear_probe_hash_table: PASSED **");
        else
            $display("** fnv1a_linear_probe_hash_table: FAILED **");
        $finish;
    end

endmodule
